/* rtl/core/posit16_product_to_quire_macros.svh */
// Assertion macros shared by the posit16 product-to-quire RTL.
`ifndef POSIT16_PRODUCT_TO_QUIRE_MACROS_SVH
`define POSIT16_PRODUCT_TO_QUIRE_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define P16Q_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("p16q check failed");

// Condition must hold in the cycle after the trigger.
`define P16Q_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("p16q check failed");

`endif

/* rtl/core/p16q_pkg.sv */
// Types and constants for the posit16 product-to-quire pipeline.
package p16q_pkg;

    localparam int CODE_W          = 16;
    localparam int BODY_W          = 15;
    localparam int MANT_W          = 11;
    localparam int EXP_W           = 9;
    localparam int SHIFT_W         = 10;
    localparam int PROD_W          = 2 * MANT_W;
    localparam int SVAL_W          = PROD_W + 1;
    localparam int LIMB_W          = 32;
    localparam int QUIRE_LIMBS     = 8;
    localparam int QUIRE_W         = LIMB_W * QUIRE_LIMBS;
    localparam int QUIRE_FRAC_BITS = 96;
    localparam int POS_W           = 8;

    typedef struct packed {
        logic [CODE_W-1:0] a_code;
        logic [CODE_W-1:0] b_code;
    } in_word_t;

    typedef struct packed {
        logic [LIMB_W-1:0] limb7;
        logic [LIMB_W-1:0] limb6;
        logic [LIMB_W-1:0] limb5;
        logic [LIMB_W-1:0] limb4;
        logic [LIMB_W-1:0] limb3;
        logic [LIMB_W-1:0] limb2;
        logic [LIMB_W-1:0] limb1;
        logic [LIMB_W-1:0] limb0;
    } out_word_t;

    typedef struct packed {
        logic                    zero;
        logic                    sign;
        logic [MANT_W-1:0]       mant;
        logic signed [EXP_W-1:0] exp2;
    } dec_t;

endpackage

/* rtl/core/p16q_decode.sv */
// Posit<16,3> operand decoder: sign, hidden-one mantissa and binary exponent.
module p16q_decode (
    input  logic [p16q_pkg::CODE_W-1:0] code,
    output p16q_pkg::dec_t              dec
);
    import p16q_pkg::*;

    logic [BODY_W-1:0]       body;
    logic [BODY_W-1:0]       norm;
    logic [BODY_W-1:0]       rem;
    logic [3:0]              run;
    logic signed [5:0]       k;
    logic [3:0]              left;
    logic [1:0]              ew;
    logic [3:0]              fw;
    logic [2:0]              e_raw;
    logic [2:0]              e;
    logic [BODY_W-1:0]       fmask;

    always_comb
    begin
        body = code[CODE_W-1] ? BODY_W'(~code[BODY_W-1:0] + 1'b1) : code[BODY_W-1:0];
        norm = body[BODY_W-1] ? ~body : body;

        run = 4'd15;
        for (int i = 0; i < BODY_W; i++)
        begin
            if (norm[i])
                run = 4'(14 - i);
        end

        if (body[BODY_W-1])
            k = $signed({2'b00, run}) - 6'sd1;
        else
            k = -$signed({2'b00, run});

        left  = (run >= 4'd14) ? 4'd0 : 4'd14 - run;
        rem   = body & BODY_W'((16'd1 << left) - 16'd1);
        ew    = (left >= 4'd3) ? 2'd3 : left[1:0];
        fw    = left - {2'b00, ew};
        e_raw = 3'((rem >> fw) & ((BODY_W'(1) << ew) - BODY_W'(1)));
        e     = e_raw << (2'd3 - ew);
        fmask = (BODY_W'(1) << fw) - BODY_W'(1);

        dec.zero = (body == '0);
        dec.sign = code[CODE_W-1];
        dec.mant = MANT_W'(rem & fmask) | (MANT_W'(1) << fw);
        dec.exp2 = $signed({k, 3'b000}) + $signed({6'b000000, e})
                 - $signed({5'b00000, fw});
    end

endmodule

/* rtl/core/p16q_place.sv */
// Quire placement: sign-extends the signed product and shifts it into 256 bits.
module p16q_place (
    input  logic signed [p16q_pkg::SVAL_W-1:0] sval,
    input  logic [p16q_pkg::POS_W-1:0]         pos,
    output p16q_pkg::out_word_t                q
);
    import p16q_pkg::*;

    logic [QUIRE_W-1:0] ext;

    always_comb
    begin
        ext = {{(QUIRE_W-SVAL_W){sval[SVAL_W-1]}}, sval};
        q   = ext << pos;
    end

endmodule

/* rtl/core/posit16_product_to_quire.sv */
// Top level: posit16 (es=3) product placed into a 256-bit two's-complement quire.
// Throughput: one word per cycle while quire_stall is low; stages are decode,
// multiply/exponent add, negate, and shift into the quire output register.
// Each stage loads when empty or when the next stage moves, so bubbles are absorbed.
// Reset clears all stage valid bits; payload registers are not reset.
`include "posit16_product_to_quire_macros.svh"

module posit16_product_to_quire (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 opnd_valid,
    output logic                 opnd_stall,
    input  p16q_pkg::in_word_t   opnd,
    output logic                 quire_valid,
    input  logic                 quire_stall,
    output p16q_pkg::out_word_t  quire
);
    import p16q_pkg::*;

    dec_t dec_a;
    dec_t dec_b;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;

    dec_t                      da_reg, db_reg;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic [POS_W-1:0]          pos2_reg, pos3_reg;
    logic                      hit2_reg, hit2_next;
    logic                      neg2_reg;
    logic signed [SVAL_W-1:0]  sval_reg, sval_next;
    logic signed [SHIFT_W-1:0] shift2;
    out_word_t                 q_next;
    out_word_t                 q_reg;

    p16q_decode u_dec_a (.code(opnd.a_code), .dec(dec_a));
    p16q_decode u_dec_b (.code(opnd.b_code), .dec(dec_b));

    p16q_place u_place (.sval(sval_reg), .pos(pos3_reg), .q(q_next));

    always_comb
    begin
        rdy4 = !v4_reg || !quire_stall;
        rdy3 = !v3_reg || rdy4;
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;

        v1_next = rdy1 ? opnd_valid : v1_reg;
        v2_next = rdy2 ? v1_reg     : v2_reg;
        v3_next = rdy3 ? v2_reg     : v3_reg;
        v4_next = rdy4 ? v3_reg     : v4_reg;

        shift2 = SHIFT_W'(da_reg.exp2) + SHIFT_W'(db_reg.exp2)
               + SHIFT_W'(QUIRE_FRAC_BITS);
        prod_next = PROD_W'(da_reg.mant) * PROD_W'(db_reg.mant);
        hit2_next = !da_reg.zero && !db_reg.zero && (shift2[SHIFT_W-1:POS_W] == '0);

        if (!hit2_reg)
            sval_next = '0;
        else if (neg2_reg)
            sval_next = -$signed({1'b0, prod_reg});
        else
            sval_next = $signed({1'b0, prod_reg});
    end

    assign opnd_stall  = !rdy1;
    assign quire_valid = v4_reg;
    assign quire       = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            da_reg <= dec_a;
            db_reg <= dec_b;
        end
        if (rdy2)
        begin
            prod_reg <= prod_next;
            pos2_reg <= shift2[POS_W-1:0];
            hit2_reg <= hit2_next;
            neg2_reg <= da_reg.sign ^ db_reg.sign;
        end
        if (rdy3)
        begin
            sval_reg <= sval_next;
            pos3_reg <= pos2_reg;
        end
        if (rdy4)
            q_reg <= q_next;
    end

    `P16Q_ASSERT_NOW(a_full_pipe_stalls, v1_reg && v2_reg && v3_reg && v4_reg && quire_stall, opnd_stall)
    `P16Q_ASSERT_NEXT(a_stage3_holds, v3_reg && !rdy4, v3_reg)
    `P16Q_ASSERT_NEXT(a_miss_gives_zero, v2_reg && rdy3 && !hit2_reg, sval_reg == '0)
    `P16Q_ASSERT_NEXT(a_zero_code_flag, opnd_valid && !opnd_stall && opnd.a_code == '0, v1_reg && da_reg.zero)

endmodule

/* tb/sv/tb_posit16_product_to_quire.sv */
`timescale 1ns / 1ps
// Self-checking testbench: posit16 pairs in, predicted quire words compared limb by limb.
module tb_posit16_product_to_quire;
    import p16q_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 12;

    localparam logic [15:0] EDGE_CODES [6] = '{
        16'h0000, 16'h8000, 16'h7FFF, 16'h8001, 16'h0001, 16'hFFFF
    };

    // a_code in the upper half, b_code in the lower half
    localparam logic [31:0] DIRECTED_PAIRS [24] = '{
        32'h0000_4000, 32'h4000_8000, 32'h4000_4000, 32'hC000_4000,
        32'hC000_C000, 32'h7FFF_7FFF, 32'h0001_0001, 32'h7FFF_4000,
        32'h7FFF_0001, 32'hFFFF_7FFF, 32'h8001_0001, 32'h8001_7FFF,
        32'h0001_4000, 32'h0001_7000, 32'h7FFF_7EE0, 32'h7FFF_7F3F,
        32'h7FFF_80C1, 32'h7FF9_4000, 32'h7FFD_C000, 32'h0003_7FFF,
        32'hFFFF_FFFF, 32'h5A5A_A5A5, 32'h3FFF_3FFF, 32'h4001_BFFF
    };

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      opnd_valid = 1'b0;
    logic      opnd_stall;
    in_word_t  opnd = '0;
    logic      quire_valid;
    logic      quire_stall = 1'b0;
    out_word_t quire;

    out_word_t pending_quire [$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    bit        send_calm = 1'b0;
    bit        recv_calm = 1'b0;
    bit        hold_quire = 1'b0;

    posit16_product_to_quire DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .opnd_valid  (opnd_valid),
        .opnd_stall  (opnd_stall),
        .opnd        (opnd),
        .quire_valid (quire_valid),
        .quire_stall (quire_stall),
        .quire       (quire)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic void decode_posit16(input logic [15:0] code, output logic sgn,
                                           output int unsigned mant, output int ex);
        int unsigned body;
        int unsigned norm;
        int unsigned run;
        int unsigned left;
        int unsigned ew;
        int unsigned fw;
        int unsigned e;
        int unsigned frac;
        int unsigned top;
        int          k;
        sgn = code[15];
        body = code[14:0];
        if (sgn)
            body = (-body) & 32'h7FFF;
        if (body == 0)
        begin
            sgn = 1'b0;
            mant = 0;
            ex = 0;
            return;
        end
        norm = body[14] ? (~body & 32'h7FFF) : body;
        if (norm == 0)
            run = 15;
        else
        begin
            top = 0;
            while ((norm >> (top + 1)) != 0)
                top++;
            run = 14 - top;
        end
        k = body[14] ? int'(run) - 1 : -int'(run);
        left = (run >= 14) ? 0 : 14 - run;
        body &= (1 << left) - 1;
        ew = (left >= 3) ? 3 : left;
        fw = left - ew;
        // missing low exponent bits read as zero
        e = ((body >> fw) & ((1 << ew) - 1)) << (3 - ew);
        frac = body & ((1 << fw) - 1);
        mant = frac + (1 << fw);
        ex = k * 8 + int'(e) - int'(fw);
    endfunction

    function automatic out_word_t quire_product(input in_word_t w);
        logic          sa;
        logic          sb;
        int unsigned   ma;
        int unsigned   mb;
        int unsigned   mp;
        int            ea;
        int            eb;
        int            sh;
        logic [255:0]  q;
        decode_posit16(w.a_code, sa, ma, ea);
        decode_posit16(w.b_code, sb, mb, eb);
        mp = ma * mb;
        sh = ea + eb + QUIRE_FRAC_BITS;
        q = '0;
        if (mp != 0 && sh >= 0 && sh < QUIRE_W)
        begin
            q = 256'(mp) << sh;
            if (sa ^ sb)
                q = -q;
        end
        return out_word_t'(q);
    endfunction

    // mostly codes with a short regime so products land inside the quire
    function automatic logic [15:0] rand_posit16();
        int unsigned pick;
        int unsigned run;
        int unsigned body;
        logic [15:0] code;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return 16'($urandom);
        if (pick == 3)
            return EDGE_CODES[$urandom_range(0, 5)];
        run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : $urandom_range(1, 6);
        body = $urandom & ((1 << (14 - run)) - 1);
        if ($urandom_range(0, 1))
            body |= ((1 << run) - 1) << (15 - run);
        else
            body |= 1 << (14 - run);
        code = {1'b0, body[14:0]};
        if ($urandom_range(0, 1))
            code = -code;
        return code;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && opnd_valid && !opnd_stall)
            pending_quire.push_back(quire_product(opnd));
    end

    always @(posedge clk)
    begin
        out_word_t want;
        bit        bad;
        if (rst_n && quire_valid && !quire_stall)
        begin
            if (pending_quire.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected quire word %h", quire);
            end
            else
            begin
                want = pending_quire.pop_front();
                bad = 1'b0;
                for (int i = 0; i < QUIRE_LIMBS; i++)
                    if (quire[i*LIMB_W +: LIMB_W] !== want[i*LIMB_W +: LIMB_W])
                        bad = 1'b1;
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("quire mismatch: expected %h got %h", want, quire);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((opnd_valid && !opnd_stall) || (quire_valid && !quire_stall))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // receiver: random hold-off per word (none while recv_calm), or one long hold on request
    initial
    begin
        int waits;
        forever
        begin
            if (hold_quire)
            begin
                hold_quire = 1'b0;
                waits = HOLD_CYCLES;
            end
            else if (recv_calm)
                waits = 0;
            else
                waits = $urandom_range(0, 7);
            repeat (waits)
            begin
                quire_stall <= 1'b1;
                @(posedge clk);
            end
            quire_stall <= 1'b0;
            do @(posedge clk); while (!quire_valid);
        end
    end

    task automatic send_word(input in_word_t w);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 7);
        repeat (gap)
        begin
            opnd_valid <= 1'b0;
            @(posedge clk);
        end
        opnd_valid <= 1'b1;
        opnd <= w;
        do @(posedge clk); while (opnd_stall);
    endtask

    task automatic test_directed();
        foreach (DIRECTED_PAIRS[i])
            send_word(in_word_t'(DIRECTED_PAIRS[i]));
    endtask

    task automatic test_random(input int count);
        send_calm = 1'b0;
        recv_calm = 1'b0;
        repeat (count)
            send_word({rand_posit16(), rand_posit16()});
    endtask

    task automatic test_streaming(input int count);
        send_calm = 1'b1;
        recv_calm = 1'b1;
        repeat (count)
            send_word({rand_posit16(), rand_posit16()});
        send_calm = 1'b0;
        recv_calm = 1'b0;
    endtask

    task automatic test_backpressure(input int count);
        send_calm = 1'b1;
        hold_quire = 1'b1;
        repeat (count)
            send_word({rand_posit16(), rand_posit16()});
        send_calm = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(900);
        test_streaming(300);
        test_backpressure(250);
        test_random(300);
        opnd_valid <= 1'b0;
        while (pending_quire.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_quire.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/p16q_pkg.sv
rtl/core/p16q_decode.sv
rtl/core/p16q_place.sv
rtl/core/posit16_product_to_quire.sv
tb/sv/tb_posit16_product_to_quire.sv
